### design/dcir_pkg.sv
// Shared types and constants for the dual-channel interpolating resampler.
// No dependencies; imported by every module of the block.
package dcir_pkg;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FETCH = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Input item
  typedef struct packed {
    logic [1:0]         cmd;
    logic               channel;
    logic signed [31:0] au_value;
    logic [26:0]        time_ms;
  } req_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] au_first;
    logic signed [31:0] au_second;
    logic               fresh;
  } pair_t;

  // One queue entry
  typedef struct packed {
    logic signed [31:0] au_first;
    logic signed [31:0] au_second;
  } pair_data_t;

  // Queue control
  typedef struct packed {
    logic clr;
    logic wr;
    logic rd;
  } q_ctl_t;

  // Shared multiply/divide unit
  localparam int MD_W = 61;   // product / dividend width
  localparam int MR_W = 28;   // multiplier / divisor width
  localparam int MC_W = 6;    // iteration counter width

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_e;

  typedef struct packed {
    logic              start;
    md_op_e            op;
    logic [MD_W-1:0]   a;
    logic [MR_W-1:0]   b;
  } md_req_t;

  localparam logic [9:0]         STEP_RESET = 10'd50;
  localparam logic [2:0]         HIST_FULL  = 3'd4;
  localparam logic signed [31:0] AU_MAX     = 32'sh7fffffff;
  localparam logic signed [31:0] AU_MIN     = 32'sh80000000;

endpackage

### design/dual_channel_interp_resampler_top.sv
// Top level of the dual-channel interpolating resampler: history, sequencer, output register.
// Depends on dcir_pkg, dcir_mdu, dcir_queue.

// Add and clear items are taken in the idle state. A fetch that finds pairs queued, or does
// not trigger generation, passes through the pop and delivery states and waits for the
// output register. A fetch that generates runs one divide for the pair count, one multiply
// for the start time, and then per pair up to two interpolations of one multiply and one
// divide each, for at most QUEUE_DEPTH pairs. These steps all run on the shared
// one-bit-per-cycle multiply/divide unit. The block takes no item while a fetch is in
// progress.
module dual_channel_interp_resampler_top #(
  parameter int QUEUE_DEPTH = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dcir_pkg::req_t    req,
  output logic              pair_valid,
  input  logic              pair_stall,
  output dcir_pkg::pair_t   pair,
  input  logic              step_we,
  input  logic [9:0]        step_data
);
  import dcir_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_N_DIV, S_T_MUL, S_LINE, S_L_MUL, S_L_DIV, S_WRITE, S_POP, S_POP_RD,
    S_DELIVER
  } state_t;

  state_t             state;
  logic [9:0]         step_ms;
  logic               hist_ch   [4];
  logic signed [31:0] hist_val  [4];
  logic [26:0]        hist_time [4];
  logic [2:0]         hist_count;
  logic               last_ch;
  logic               pending;
  pair_data_t         last_pair;
  pair_t              pend_out;
  logic [CW-1:0]      gen_left;
  logic [26:0]        t_cur;
  logic               line;
  logic signed [31:0] val_a;
  logic signed [31:0] val_b;
  md_req_t            md_req;
  logic               md_done;
  logic [MD_W-1:0]    md_res;
  q_ctl_t             q_ctl;
  pair_data_t         q_wr;
  pair_data_t         q_rd;
  logic [CW-1:0]      q_count;

  logic               accept;
  logic [9:0]         step_eff;
  logic               gen_ok;
  logic [27:0]        n_num;
  logic [27:0]        n_val;
  logic               n_big;
  logic [27:0]        start_j;
  logic signed [31:0] va;
  logic signed [31:0] vb;
  logic [26:0]        ta;
  logic [26:0]        tb;
  logic [27:0]        span_l;
  logic               span_pos;
  logic signed [32:0] diff;
  logic [27:0]        dt;
  logic [32:0]        mag_diff;
  logic [27:0]        mag_dt;
  logic               neg;
  logic [61:0]        q_s;
  logic [61:0]        sum;
  logic signed [31:0] line_val;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign step_eff  = (step_ms == 10'd0) ? 10'd1 : step_ms;

  // generation window: channels line up and the window is not empty
  assign gen_ok = (hist_ch[0] == hist_ch[2]) && (hist_ch[1] == hist_ch[3]) &&
                  (hist_time[2] > hist_time[1]);
  assign n_num  = ({1'b0, hist_time[2]} - {1'b0, hist_time[1]}) + 28'(step_eff) - 28'd1;
  assign n_val  = md_res[27:0];
  assign n_big  = n_val > 28'(QUEUE_DEPTH);
  assign start_j = n_big ? n_val - 28'(QUEUE_DEPTH) : 28'd0;

  // operands of the channel line under work
  assign va = line ? hist_val[1]  : hist_val[0];
  assign ta = line ? hist_time[1] : hist_time[0];
  assign vb = line ? hist_val[3]  : hist_val[2];
  assign tb = line ? hist_time[3] : hist_time[2];
  assign span_l   = {1'b0, tb} - {1'b0, ta};
  assign span_pos = tb > ta;
  assign diff     = {vb[31], vb} - {va[31], va};
  assign dt       = {1'b0, t_cur} - {1'b0, ta};
  assign mag_diff = diff[32] ? 33'(-diff) : 33'(diff);
  assign mag_dt   = dt[27] ? -dt : dt;
  assign neg      = diff[32] ^ dt[27];

  // sign the quotient, add the base value and saturate
  assign q_s = neg ? -{1'b0, md_res} : {1'b0, md_res};
  assign sum = {{30{va[31]}}, va} + q_s;
  always_comb begin
    if (!sum[61] && (sum[60:31] != '0))
      line_val = AU_MAX;
    else if (sum[61] && (sum[60:31] != '1))
      line_val = AU_MIN;
    else
      line_val = sum[31:0];
  end

  // queue control
  always_comb begin
    q_ctl.clr = (state == S_N_DIV);
    q_ctl.wr  = (state == S_WRITE);
    q_ctl.rd  = (state == S_POP) && (q_count != '0);
  end
  assign q_wr = hist_ch[0] ? pair_data_t'{au_first: val_b, au_second: val_a}
                           : pair_data_t'{au_first: val_a, au_second: val_b};

  // multiply/divide requests, issued at the edge that leaves each state
  always_comb begin
    md_req = '0;
    case (state)
      S_IDLE: begin
        if (accept && (req.cmd == CMD_FETCH) && (q_count == '0) && pending &&
            (hist_count == HIST_FULL) && gen_ok)
          md_req = '{start: 1'b1, op: MD_DIV, a: MD_W'(n_num), b: MR_W'(step_eff)};
      end
      S_N_DIV: begin
        if (md_done)
          md_req = '{start: 1'b1, op: MD_MUL, a: MD_W'(step_eff), b: start_j};
      end
      S_LINE: begin
        if (span_pos)
          md_req = '{start: 1'b1, op: MD_MUL, a: MD_W'(mag_diff), b: mag_dt};
      end
      S_L_MUL: begin
        if (md_done)
          md_req = '{start: 1'b1, op: MD_DIV, a: md_res, b: span_l};
      end
      default: md_req = '0;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms <= STEP_RESET;
    end else if (step_we) begin
      step_ms <= step_data;
    end
  end

  // sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count <= '0;
      last_ch    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hist_ch[i]   <= 1'b0;
        hist_val[i]  <= '0;
        hist_time[i] <= '0;
      end
    end else if (accept && (req.cmd == CMD_CLEAR)) begin
      hist_count <= '0;
    end else if (accept && (req.cmd == CMD_ADD) &&
                 !((hist_count != '0) && (last_ch == req.channel))) begin
      last_ch <= req.channel;
      if (hist_count == HIST_FULL) begin
        for (int i = 0; i < 3; i++) begin
          hist_ch[i]   <= hist_ch[i+1];
          hist_val[i]  <= hist_val[i+1];
          hist_time[i] <= hist_time[i+1];
        end
        hist_ch[3]   <= req.channel;
        hist_val[3]  <= req.au_value;
        hist_time[3] <= req.time_ms;
      end else begin
        hist_ch[hist_count[1:0]]   <= req.channel;
        hist_val[hist_count[1:0]]  <= req.au_value;
        hist_time[hist_count[1:0]] <= req.time_ms;
        hist_count <= hist_count + 3'd1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pending    <= 1'b0;
      last_pair  <= '0;
      pair_valid <= 1'b0;
      gen_left   <= '0;
      line       <= 1'b0;
    end else begin
      // output register: load on delivery, drop once taken
      if ((state == S_DELIVER) && (!pair_valid || !pair_stall)) begin
        pair       <= pend_out;
        pair_valid <= 1'b1;
      end else if (pair_valid && !pair_stall) begin
        pair_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req.cmd == CMD_ADD) &&
              !((hist_count != '0) && (last_ch == req.channel))) begin
            pending <= 1'b1;
          end
          if (accept && (req.cmd == CMD_FETCH)) begin
            state <= S_POP;
            if ((q_count == '0) && pending && (hist_count == HIST_FULL)) begin
              pending <= 1'b0;
              if (gen_ok) begin
                state <= S_N_DIV;
              end
            end
          end
        end
        S_N_DIV: begin
          if (md_done) begin
            gen_left <= n_big ? CW'(QUEUE_DEPTH) : n_val[CW-1:0];
            state    <= S_T_MUL;
          end
        end
        S_T_MUL: begin
          if (md_done) begin
            t_cur <= hist_time[1] + md_res[26:0];
            line  <= 1'b0;
            state <= S_LINE;
          end
        end
        S_LINE: begin
          if (!span_pos) begin
            // flat line: value holds
            if (!line) begin
              val_a <= va;
              line  <= 1'b1;
            end else begin
              val_b <= va;
              state <= S_WRITE;
            end
          end else begin
            state <= S_L_MUL;
          end
        end
        S_L_MUL: begin
          if (md_done) begin
            state <= S_L_DIV;
          end
        end
        S_L_DIV: begin
          if (md_done) begin
            if (!line) begin
              val_a <= line_val;
              line  <= 1'b1;
              state <= S_LINE;
            end else begin
              val_b <= line_val;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          t_cur    <= t_cur + 27'(step_eff);
          gen_left <= gen_left - 1'b1;
          line     <= 1'b0;
          state    <= (gen_left == CW'(1)) ? S_POP : S_LINE;
        end
        S_POP: begin
          if (q_count == '0) begin
            pend_out <= '{au_first: last_pair.au_first, au_second: last_pair.au_second,
                          fresh: 1'b0};
            state    <= S_DELIVER;
          end else begin
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          last_pair <= q_rd;
          pend_out  <= '{au_first: q_rd.au_first, au_second: q_rd.au_second, fresh: 1'b1};
          state     <= S_DELIVER;
        end
        S_DELIVER: begin
          if (!pair_valid || !pair_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dcir_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .res  (md_res)
  );

  dcir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .wr_data (q_wr),
    .rd_data (q_rd),
    .count   (q_count)
  );

  // a result appears only from the delivery step
  a_rise_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(pair_valid) |-> $past(state == S_DELIVER))
    else $error("result raised outside delivery");

  // the queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // a queue read is always followed by its capture
  a_pop_capture: assert property (@(posedge clk) disable iff (rst)
    q_ctl.rd |=> (state == S_POP_RD))
    else $error("queue read without capture");

endmodule

### design/dcir_mdu.sv
// Iterative unsigned multiply (shift-add) and divide (restoring), one bit per cycle.
// Depends on dcir_pkg.
module dcir_mdu (
  input  logic                        clk,
  input  logic                        rst,
  input  dcir_pkg::md_req_t           req,
  output logic                        done,
  output logic [dcir_pkg::MD_W-1:0]   res
);
  import dcir_pkg::*;

  logic            busy;
  md_op_e          op;
  logic [MC_W-1:0] cnt;
  logic [MD_W-1:0] acc;
  logic [MD_W-1:0] mc;
  logic [MR_W-1:0] mr;
  logic [MR_W:0]   rem;
  logic [MR_W:0]   rem_sh;

  assign res = acc;
  assign rem_sh = {rem[MR_W-1:0], acc[MD_W-1]};

  // control: busy flag, iteration count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == MD_MUL) ? MC_W'(MR_W) : MC_W'(MD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == MC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: one add or one compare/subtract per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      acc <= (req.op == MD_MUL) ? '0 : req.a;
      mc  <= req.a;
      mr  <= req.b;
      rem <= '0;
    end else if (busy) begin
      if (op == MD_MUL) begin
        if (mr[0]) acc <= acc + mc;
        mc <= {mc[MD_W-2:0], 1'b0};
        mr <= {1'b0, mr[MR_W-1:1]};
      end else begin
        if (rem_sh >= {1'b0, mr}) begin
          rem <= rem_sh - {1'b0, mr};
          acc <= {acc[MD_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[MD_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

### design/dcir_queue.sv
// Pair queue: memory with write/read pointers and fill count, registered read.
// Depends on dcir_pkg.
module dcir_queue #(
  parameter int DEPTH = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcir_pkg::q_ctl_t              ctl,
  input  dcir_pkg::pair_data_t          wr_data,
  output dcir_pkg::pair_data_t          rd_data,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import dcir_pkg::*;

  localparam int AW = $clog2(DEPTH);

  pair_data_t     mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (ctl.wr) mem[wr_ptr] <= wr_data;
    if (ctl.rd) rd_data <= mem[rd_ptr];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else if (ctl.wr) begin
      wr_ptr <= wr_ptr + 1'b1;
      count  <= count + 1'b1;
    end else if (ctl.rd) begin
      rd_ptr <= rd_ptr + 1'b1;
      count  <= count - 1'b1;
    end
  end

endmodule

### sim/dual_channel_interp_resampler_top_tb.sv
// Testbench for the dual-channel interpolating resampler: directed and random
// items with a scoreboard that predicts every fetched pair.
// Depends on dcir_pkg and dual_channel_interp_resampler_top.
`timescale 1ns / 100ps

module dual_channel_interp_resampler_top_tb;
  import dcir_pkg::*;

  localparam int QDEPTH = 30;

  // Predictor of fetched pairs plus the store of expected pairs
  class pair_scoreboard;
    bit [9:0] step;
    bit hch[4];
    longint hval[4];
    longint htime[4];
    int hcnt;
    bit pending;
    longint qa[$];
    longint qb[$];
    longint last_a, last_b;
    pair_t expected[$];
    int mismatches;
    int checked;

    function new();
      step = STEP_RESET;
      hcnt = 0;
      pending = 0;
      last_a = 0;
      last_b = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function longint lerp(longint va, longint ta, longint vb, longint tb, longint t);
      longint span;
      longint v;
      span = tb - ta;
      if (span <= 0) return va;
      v = va + ((vb - va) * (t - ta)) / span;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v;
    endfunction

    // Refill the pair queue from the held window when allowed
    function void resample();
      longint t2, span, st, n, first, t, a, b, s;
      if (qa.size() != 0 || !pending || hcnt < 4) return;
      pending = 0;
      if (hch[0] != hch[2] || hch[1] != hch[3]) return;
      t2 = htime[1];
      span = htime[2] - t2;
      if (span <= 0) return;
      st = (step == 0) ? 1 : step;
      n = (span + st - 1) / st;
      first = (n > QDEPTH) ? n - QDEPTH : 0;
      for (longint j = first; j < n; j++) begin
        t = t2 + j * st;
        a = lerp(hval[0], htime[0], hval[2], htime[2], t);
        b = lerp(hval[1], htime[1], hval[3], htime[3], t);
        if (hch[0]) begin
          s = a; a = b; b = s;
        end
        qa.push_back(a);
        qb.push_back(b);
      end
    endfunction

    // Note an accepted input item
    function void note_item(req_t r);
      pair_t p;
      case (r.cmd)
        CMD_ADD: begin
          if (hcnt > 0 && hch[hcnt-1] == r.channel) return;
          if (hcnt == 4) begin
            for (int i = 0; i < 3; i++) begin
              hch[i] = hch[i+1]; hval[i] = hval[i+1]; htime[i] = htime[i+1];
            end
            hcnt--;
          end
          hch[hcnt] = r.channel;
          hval[hcnt] = longint'(r.au_value);
          htime[hcnt] = longint'({37'd0, r.time_ms});
          hcnt++;
          pending = 1;
        end
        CMD_CLEAR: hcnt = 0;
        CMD_FETCH: begin
          resample();
          if (qa.size() == 0) p.fresh = 0;
          else begin
            last_a = qa.pop_front();
            last_b = qb.pop_front();
            p.fresh = 1;
          end
          p.au_first = last_a[31:0];
          p.au_second = last_b[31:0];
          expected.push_back(p);
        end
        default: ;
      endcase
    endfunction

    function void report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endfunction

    // Check one accepted result against the oldest expectation
    function void check_pair(pair_t got);
      pair_t e;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("unexpected pair %h", got));
        return;
      end
      e = expected.pop_front();
      checked++;
      if (got.au_first !== e.au_first)
        report_mismatch($sformatf("au_first %h want %h", got.au_first, e.au_first));
      if (got.au_second !== e.au_second)
        report_mismatch($sformatf("au_second %h want %h", got.au_second, e.au_second));
      if (got.fresh !== e.fresh)
        report_mismatch($sformatf("fresh %b want %b", got.fresh, e.fresh));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic pair_valid;
  logic pair_stall = 0;
  pair_t pair;
  logic step_we = 0;
  logic [9:0] step_data = '0;

  pair_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int items_sent = 0;
  int fetches_sent = 0;

  dual_channel_interp_resampler_top #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
    .step_we(step_we), .step_data(step_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stall, check on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && !pair_stall) sb.check_pair(pair);
      pair_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Send one item, with optional idle cycles before it
  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_item(r);
    items_sent++;
    if (r.cmd == CMD_FETCH) fetches_sent++;
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_step(bit [9:0] v);
    drain();
    step_we <= 1;
    step_data <= v;
    @(posedge clk);
    step_we <= 0;
    sb.step = v;
  endtask

  function automatic req_t mk(cmd_e c, bit ch, logic signed [31:0] v, bit [26:0] t);
    req_t r;
    r.cmd = c; r.channel = ch; r.au_value = v; r.time_ms = t;
    return r;
  endfunction

  // Well-formed sequence: four alternating samples, then up to four fetches and at times a random item
  task automatic rand_sequence();
    bit ch0;
    bit [26:0] t;
    int nf;
    req_t r;
    ch0 = 1'($urandom_range(1));
    t = $urandom_range(1) ? 27'($urandom) : 27'($urandom_range(5000));
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(9) == 0) t = 27'($urandom);
      else t = 27'(t + $urandom_range(400));
      send_item(mk(CMD_ADD, ch0 ^ i[0], $urandom_range(3) == 0 ? $urandom
                   : $signed($urandom_range(200000)) - 100000, t));
    end
    nf = $urandom_range(4);
    for (int i = 0; i < nf; i++) send_item(mk(CMD_FETCH, 0, 0, 0));
    // some noise
    if ($urandom_range(4) == 0) begin
      r = req_t'(62'({$urandom, $urandom}));
      r.time_ms = 27'($urandom);
      send_item(r);
    end
  endtask

  task automatic random_phase(int sidle, int rstall, int n);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) rand_sequence();
      else send_item(mk(CMD_FETCH, 0, 0, 0));
    end
  endtask

  initial begin
    int hold_cnt;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, saturation, repeated channel, clear, cmd 3, empty window
    send_item(mk(CMD_FETCH, 0, 0, 0));
    send_item(mk(CMD_ADD, 0, 32'sh7fffffff, 27'd0));
    send_item(mk(CMD_ADD, 0, 32'sh0, 27'd5));
    send_item(mk(CMD_ADD, 1, 32'sh80000000, 27'd0));
    send_item(mk(CMD_ADD, 0, 32'sh80000000, 27'd200));
    send_item(mk(CMD_ADD, 1, 32'sh7fffffff, 27'd100));
    send_item(mk(CMD_FETCH, 0, 0, 0));
    send_item(mk(CMD_FETCH, 0, 0, 0));
    send_item(mk(CMD_ADD, 0, 32'sh7fffffff, 27'h7ffffff));
    send_item(mk(CMD_FETCH, 0, 0, 0));
    send_item(mk(CMD_CLEAR, 0, 0, 0));
    send_item('{cmd: 2'd3, channel: 1'b1, au_value: 32'hffffffff, time_ms: 27'h7ffffff});
    send_item(mk(CMD_ADD, 1, 32'sh10000, 27'd1000));
    send_item(mk(CMD_ADD, 0, -32'sh10000, 27'd900));
    send_item(mk(CMD_ADD, 1, 32'sh20000, 27'd800));
    send_item(mk(CMD_ADD, 0, 32'sh30000, 27'd1300));
    send_item(mk(CMD_FETCH, 0, 0, 0));
    send_item(mk(CMD_FETCH, 0, 0, 0));

    write_step(10'd1);
    send_item(mk(CMD_ADD, 0, 32'sh100, 27'd0));
    send_item(mk(CMD_ADD, 1, 32'sh200, 27'd10));
    send_item(mk(CMD_ADD, 0, 32'sh50000, 27'd100));
    send_item(mk(CMD_ADD, 1, -32'sh50000, 27'd120));
    send_item(mk(CMD_FETCH, 0, 0, 0));

    write_step(10'd0);
    random_phase(0, 0, 20);
    write_step(10'd1023);
    random_phase(72, 0, 35);
    write_step(10'd1000);
    random_phase(0, 72, 35);
    write_step(10'd7);
    random_phase(28, 28, 35);

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1;
    send_idle_pct = 0;
    fork
      begin
        hold_cnt = 0;
        while (hold_cnt < 3000) begin
          @(posedge clk);
          hold_cnt++;
        end
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 8; i++) send_item(mk(CMD_FETCH, 0, 0, 0));
      end
    join
    drain();

    write_step(10'd50);
    random_phase(0, 0, 30);
    write_step(10'd333);
    random_phase(72, 72, 25);
    drain();

    $display("Sent %0d items (%0d fetches), checked %0d pairs over several step settings.",
             items_sent, fetches_sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Time limit
  initial begin
    #300ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
